### hw/rtl/aes_style_block_encrypt_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the block encrypt core
// Concurrent assertion wrappers that compile to nothing when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef AES_STYLE_BLOCK_ENCRYPT_CORE_MACROS_SVH
`define AES_STYLE_BLOCK_ENCRYPT_CORE_MACROS_SVH

`ifndef ASSERT_OFF
`define AESBE_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define AESBE_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("assertion failed");
`else
`define AESBE_ASSERT(lbl, clk, rst, prop)
`define AESBE_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

### hw/rtl/aesbe_pkg.sv
// ----------------------------------------------------------------------------
// Block encrypt package
// Shared types, register indexes, reset values and the substitution table.
// ----------------------------------------------------------------------------
`default_nettype none

package aesbe_pkg;

   localparam int unsigned BLOCK_W = 128;
   localparam int unsigned HALF_W  = 64;
   localparam int unsigned ROUND_W = 4;
   localparam int unsigned CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_KEY_HIGH    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LOW     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROUND_COUNT = 2'd2;

   localparam logic [ROUND_W-1:0] RESET_ROUND_COUNT = 4'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROUND,
      ST_LAST
   } state_type;

   typedef struct packed {
      logic load;
      logic round;
      logic last_round;
   } cmd_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

endpackage

`default_nettype wire

### hw/rtl/aes_style_block_encrypt_core.sv
// ----------------------------------------------------------------------------
// AES-style block encrypt core
// Encrypts 128-bit words with one unexpanded key over a configurable round count.
//
//   Channel  Direction  Handshake          Payload
//   req      in         valid / stall      block_high, block_low
//   rsp      out        valid / stall      cipher_high, cipher_low
//   csr      in         valid / ready      index, data (64 bits)
//
// One word passes through the round unit in order: a load step, one step per
// full round (round_count of them) and one step for the final round.
// The next word is accepted while a finished word waits in the output register.
// A stalled output holds the final round until the output register frees up.
// Reset is synchronous; the key resets to zero and the round count to two.
// ----------------------------------------------------------------------------
`default_nettype none

module aes_style_block_encrypt_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [aesbe_pkg::HALF_W-1:0]    req_block_high,
   input  wire logic [aesbe_pkg::HALF_W-1:0]    req_block_low,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic      [aesbe_pkg::HALF_W-1:0]    rsp_cipher_high,
   output logic      [aesbe_pkg::HALF_W-1:0]    rsp_cipher_low,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [aesbe_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [aesbe_pkg::HALF_W-1:0]    csr_data
);

   logic [aesbe_pkg::HALF_W-1:0]  key_high_ff;
   logic [aesbe_pkg::HALF_W-1:0]  key_low_ff;
   logic [aesbe_pkg::ROUND_W-1:0] round_count_ff;
   logic [aesbe_pkg::BLOCK_W-1:0] cipher;
   aesbe_pkg::cmd_type            cmd;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff    <= '0;
         key_low_ff     <= '0;
         round_count_ff <= aesbe_pkg::RESET_ROUND_COUNT;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            aesbe_pkg::CSR_KEY_HIGH:    key_high_ff    <= csr_data;
            aesbe_pkg::CSR_KEY_LOW:     key_low_ff     <= csr_data;
            aesbe_pkg::CSR_ROUND_COUNT: round_count_ff <= csr_data[aesbe_pkg::ROUND_W-1:0];
            default: begin
            end
         endcase
      end
   end

   aesbe_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .round_count (round_count_ff),
      .cmd         (cmd)
   );

   aesbe_datapath u_datapath (
      .clock  (clock),
      .cmd    (cmd),
      .block  ({req_block_high, req_block_low}),
      .key    ({key_high_ff, key_low_ff}),
      .cipher (cipher)
   );

   assign rsp_cipher_high = cipher[aesbe_pkg::BLOCK_W-1:aesbe_pkg::HALF_W];
   assign rsp_cipher_low  = cipher[aesbe_pkg::HALF_W-1:0];

endmodule

`default_nettype wire

### hw/rtl/aesbe_datapath.sv
// ----------------------------------------------------------------------------
// Block encrypt datapath
// State register, one shared round unit and the ciphertext output register.
// ----------------------------------------------------------------------------
`default_nettype none

module aesbe_datapath (
   input  wire logic                          clock,
   input  wire aesbe_pkg::cmd_type            cmd,
   input  wire logic [aesbe_pkg::BLOCK_W-1:0] block,
   input  wire logic [aesbe_pkg::BLOCK_W-1:0] key,
   output logic      [aesbe_pkg::BLOCK_W-1:0] cipher
);

   logic [aesbe_pkg::BLOCK_W-1:0] state_ff;
   logic [aesbe_pkg::BLOCK_W-1:0] state_in;
   logic [aesbe_pkg::BLOCK_W-1:0] cipher_ff;
   logic [aesbe_pkg::BLOCK_W-1:0] shifted;
   logic [aesbe_pkg::BLOCK_W-1:0] mixed;

   function automatic logic [7:0] xtime(input logic [7:0] v);
      return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [127:0] sub_shift(input logic [127:0] s);
      logic [127:0] t;
      t = '0;
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            t[127 - 8 * (4 * c + r) -: 8] =
               aesbe_pkg::SBOX[s[127 - 8 * (4 * ((c + r) & 3) + r) -: 8]];
         end
      end
      return t;
   endfunction

   function automatic logic [127:0] mix_state(input logic [127:0] s);
      logic [127:0] t;
      logic [7:0]   a0, a1, a2, a3;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         a0 = s[127 - 8 * (4 * c)     -: 8];
         a1 = s[127 - 8 * (4 * c + 1) -: 8];
         a2 = s[127 - 8 * (4 * c + 2) -: 8];
         a3 = s[127 - 8 * (4 * c + 3) -: 8];
         t[127 - 8 * (4 * c)     -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
         t[127 - 8 * (4 * c + 1) -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
         t[127 - 8 * (4 * c + 2) -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
         t[127 - 8 * (4 * c + 3) -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
      end
      return t;
   endfunction

   assign shifted = sub_shift(state_ff);
   assign mixed   = mix_state(shifted);

   always_comb begin
      state_in = state_ff;
      if (cmd.load) begin
         state_in = block ^ key;
      end else if (cmd.round) begin
         state_in = mixed ^ key;
      end
   end

   always_ff @(posedge clock) begin
      state_ff <= state_in;
      if (cmd.last_round) begin
         cipher_ff <= shifted ^ key;
      end
   end

   assign cipher = cipher_ff;

endmodule

`default_nettype wire

### hw/rtl/aesbe_ctrl.sv
// ----------------------------------------------------------------------------
// Block encrypt controller
// Sequences load, full rounds and the final round, and owns the result valid.
// ----------------------------------------------------------------------------
`default_nettype none
`include "aes_style_block_encrypt_core_macros.svh"

module aesbe_ctrl (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   input  wire logic [aesbe_pkg::ROUND_W-1:0] round_count,
   output aesbe_pkg::cmd_type                 cmd
);

   aesbe_pkg::state_type          state_ff;
   aesbe_pkg::state_type          state_in;
   logic [aesbe_pkg::ROUND_W-1:0] round_index_ff;
   logic [aesbe_pkg::ROUND_W-1:0] round_index_in;
   logic [aesbe_pkg::ROUND_W-1:0] round_next;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic                          out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= aesbe_pkg::ST_IDLE;
         round_index_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         round_index_ff <= round_index_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   assign round_next = round_index_ff + 4'd1;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in       = state_ff;
      round_index_in = round_index_ff;
      cmd            = '0;
      req_stall      = 1'b1;
      case (state_ff)
         aesbe_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load       = 1'b1;
               round_index_in = '0;
               state_in       = (round_count == '0) ? aesbe_pkg::ST_LAST
                                                    : aesbe_pkg::ST_ROUND;
            end
         end
         aesbe_pkg::ST_ROUND: begin
            cmd.round      = 1'b1;
            round_index_in = round_next;
            if (round_next == round_count) begin
               state_in = aesbe_pkg::ST_LAST;
            end
         end
         aesbe_pkg::ST_LAST: begin
            if (out_free) begin
               cmd.last_round = 1'b1;
               state_in       = aesbe_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = aesbe_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.last_round) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `AESBE_ASSERT(a_cmd_onehot, clock, reset, $onehot0({cmd.load, cmd.round, cmd.last_round}))
   `AESBE_ASSERT(a_no_overwrite, clock, reset, cmd.last_round |-> out_free)
   `AESBE_ASSERT(a_valid_from_last, clock, reset, $rose(rsp_valid_ff) |-> $past(cmd.last_round))
   `AESBE_ASSERT(a_round_bound, clock, reset, (state_ff == aesbe_pkg::ST_ROUND) |-> (round_index_ff < round_count))

endmodule

`default_nettype wire
